FILE: sv/johnson_all_pairs_shortest_paths_core_macros.svh
// Assertion macros for the core RTL file.
`ifndef JOHNSON_ALL_PAIRS_SHORTEST_PATHS_CORE_MACROS_SVH
`define JOHNSON_ALL_PAIRS_SHORTEST_PATHS_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define JAP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JAP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JAP_ASSERT(label, clk, rst_n, prop, msg)
`define JAP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: sv/jap_pkg.sv
package jap_pkg;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_READ    = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NEG  = 2'd2;
	localparam logic [1:0] STAT_NC   = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_P_CLR,
		ST_E_RD,
		ST_E_FROM,
		ST_E_TO,
		ST_E_UPD,
		ST_RW_CLR,
		ST_DJ_INIT,
		ST_DJ_POT,
		ST_DJ_SEL,
		ST_DJ_REL,
		ST_DJ_OUT,
		ST_READ,
		ST_READ2,
		ST_FIN
	} state_t;

endpackage

FILE: sv/jap_ram.sv
module jap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/johnson_all_pairs_shortest_paths_core.sv
// Johnson all-pairs shortest paths engine. Pulse start with op while busy is low; busy stays
// high until the transaction finishes, and done then pulses for one cycle with the result on
// status and the read fields. The result cannot be held off, so capture it on done. Add walks
// the stored edges one per cycle looking for the same pair. Compute is bound by the single read
// port of the potential memory and the tentative-distance memory: Bellman-Ford, reweighting and
// clearing the reweighted matrix, then for each of the n sources Dijkstra selection and
// relaxation.
`include "johnson_all_pairs_shortest_paths_core_macros.svh"
module johnson_all_pairs_shortest_paths_core #(
	parameter int MAX_NODES   = 32,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [4:0]         src_node,
	input  logic [4:0]         dst_node,
	input  logic signed [15:0] edge_weight,
	output logic               done,
	output logic [1:0]         status,
	output logic               reachable,
	output logic signed [31:0] distance,
	output logic               edge_present,
	output logic [30:0]        reweighted_weight
);

	localparam int NB    = $clog2(MAX_NODES);
	localparam int NCW   = $clog2(MAX_NODES + 1);
	localparam int EA    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW   = $clog2(MAX_EDGES + 1);
	localparam int MA    = $clog2(MAX_NODES * MAX_NODES);
	localparam int EW    = 10 + WEIGHT_BITS;
	localparam int POT_W = WEIGHT_BITS + $clog2(MAX_NODES) + $clog2(MAX_EDGES + 1) + 1;
	localparam int RW_W  = POT_W + 1;
	localparam int TD_W  = RW_W + NB;
	localparam int DV_W  = TD_W + 2;

	jap_pkg::state_t state_q, state_d;

	// Control registers.
	logic [5:0]           node_count_q;
	logic                 flag_done_q, flag_cycle_q;
	logic [ECW-1:0]       edge_cnt_q, idx_q;
	logic [NCW-1:0]       computed_n_q, pass_q, row_q, col_q, src_q;
	logic                 phase_q, have_best_q, rv_s1, done_q;
	logic [MAX_NODES-1:0] tvalid_q, visited_q;

	// Payload registers.
	logic [4:0]                    s_q, d_q, ef_q, et_q;
	logic signed [WEIGHT_BITS-1:0] w_q, ew_q;
	logic signed [POT_W-1:0]       pf_q, ps_q;
	logic [EA-1:0]                 ei_s1;
	logic [NB-1:0]                 ri_s1, best_q;
	logic [TD_W-1:0]               best_d_q;
	logic [1:0]                    status_q;
	logic                          reach_q, present_q;
	logic signed [31:0]            dist_q;
	logic [30:0]                   rw_q;

	// Memory ports.
	logic                e_we;
	logic [EA-1:0]       e_waddr, e_raddr;
	logic [EW-1:0]       e_wdata, e_rdata;
	logic                p_we;
	logic [NB-1:0]       p_waddr, p_raddr;
	logic [POT_W-1:0]    p_wdata, p_rdata;
	logic                rw_we;
	logic [MA-1:0]       rw_waddr, rw_raddr;
	logic [RW_W:0]       rw_wdata, rw_rdata;
	logic                d_we;
	logic [MA-1:0]       d_waddr, d_raddr;
	logic [DV_W:0]       d_wdata, d_rdata;
	logic                t_we;
	logic [NB-1:0]       t_waddr, t_raddr;
	logic [TD_W-1:0]     t_wdata, t_rdata;

	// Combinational helpers.
	logic [NCW-1:0]                n_c, n_m1;
	logic [23:0]                   w_ext;
	logic signed [WEIGHT_BITS-1:0] w_in, rd_w;
	logic [4:0]                    rd_from, rd_to;
	logic                          edge_in, issue_e, issue_n, pair_match, add_new;
	logic signed [POT_W-1:0]       pt;
	logic signed [POT_W:0]         cand;
	logic                          less;
	logic signed [POT_W+1:0]       rwv;
	logic [MA-1:0]                 clr_addr, edge_addr, rel_addr, out_addr, pair_addr;
	logic                          rw_pres;
	logic [RW_W-1:0]               rw_val;
	logic [TD_W:0]                 nd;
	logic                          relax_upd, sel_better, scan_end, in_range;
	logic signed [DV_W-1:0]        dv, d_val;
	logic signed [63:0]            dv64;
	logic [63:0]                   rw64;
	logic                          fin, fin_reach, fin_present;
	logic [1:0]                    fin_status;
	logic signed [31:0]            fin_dist;
	logic [30:0]                   fin_rw;

	jap_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);
	jap_ram #(.WIDTH(POT_W), .DEPTH(MAX_NODES)) u_pot_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);
	jap_ram #(.WIDTH(RW_W + 1), .DEPTH(MAX_NODES * MAX_NODES)) u_rw_ram (
		.clk(clk), .we(rw_we), .waddr(rw_waddr), .wdata(rw_wdata),
		.raddr(rw_raddr), .rdata(rw_rdata)
	);
	jap_ram #(.WIDTH(DV_W + 1), .DEPTH(MAX_NODES * MAX_NODES)) u_dist_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);
	jap_ram #(.WIDTH(TD_W), .DEPTH(MAX_NODES)) u_tent_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	always_comb begin
		if (node_count_q == 6'd0) begin
			n_c = NCW'(1);
		end else if (10'(node_count_q) > 10'(MAX_NODES)) begin
			n_c = NCW'(MAX_NODES);
		end else begin
			n_c = NCW'(node_count_q);
		end
	end

	assign n_m1     = computed_n_q - NCW'(1);
	assign w_ext    = {{8{edge_weight[15]}}, edge_weight};
	assign w_in     = w_ext[WEIGHT_BITS-1:0];
	assign rd_from  = e_rdata[EW-1 -: 5];
	assign rd_to    = e_rdata[EW-6 -: 5];
	assign rd_w     = e_rdata[WEIGHT_BITS-1:0];
	assign edge_in  = (10'(rd_from) < 10'(computed_n_q)) && (10'(rd_to) < 10'(computed_n_q));
	assign issue_e  = idx_q < edge_cnt_q;
	assign issue_n  = col_q < computed_n_q;
	assign scan_end = !issue_n && !rv_s1;
	assign pair_match = rv_s1 && (rd_from == s_q) && (rd_to == d_q);
	assign add_new  = !pair_match && !issue_e && !rv_s1 && (edge_cnt_q != ECW'(MAX_EDGES));

	assign pt   = p_rdata;
	assign cand = (POT_W+1)'(pf_q) + (POT_W+1)'(ew_q);
	assign less = cand < (POT_W+1)'(pt);
	assign rwv  = (POT_W+2)'(ew_q) + (POT_W+2)'(pf_q) - (POT_W+2)'(pt);

	assign clr_addr  = MA'(row_q) * MA'(MAX_NODES) + MA'(col_q);
	assign edge_addr = MA'(ef_q) * MA'(MAX_NODES) + MA'(et_q);
	assign rel_addr  = MA'(best_q) * MA'(MAX_NODES) + MA'(col_q);
	assign out_addr  = MA'(src_q) * MA'(MAX_NODES) + MA'(ri_s1);
	assign pair_addr = MA'(s_q) * MA'(MAX_NODES) + MA'(d_q);

	assign rw_pres = rw_rdata[RW_W];
	assign rw_val  = rw_rdata[RW_W-1:0];
	assign nd      = (TD_W+1)'(best_d_q) + (TD_W+1)'(rw_val);
	assign relax_upd = rv_s1 && rw_pres && (!tvalid_q[ri_s1] || (nd < {1'b0, t_rdata}));
	assign sel_better = rv_s1 && tvalid_q[ri_s1] && !visited_q[ri_s1]
		&& (!have_best_q || (t_rdata < best_d_q));

	// Distance is the reweighted length with the potentials taken back out.
	assign dv    = $signed({2'b00, t_rdata}) - DV_W'(ps_q) + DV_W'(pt);
	assign d_val = d_rdata[DV_W-1:0];
	assign dv64  = 64'(d_val);
	assign rw64  = 64'(rw_val);
	assign in_range = (10'(s_q) < 10'(computed_n_q)) && (10'(d_q) < 10'(computed_n_q));

	always_comb begin
		state_d     = state_q;
		fin         = 1'b0;
		fin_status  = jap_pkg::STAT_OK;
		fin_reach   = 1'b0;
		fin_dist    = '0;
		fin_present = 1'b0;
		fin_rw      = '0;
		e_we        = 1'b0;
		e_waddr     = edge_cnt_q[EA-1:0];
		e_wdata     = {s_q, d_q, w_q};
		e_raddr     = idx_q[EA-1:0];
		p_we        = 1'b0;
		p_waddr     = NB'(et_q);
		p_wdata     = '0;
		p_raddr     = col_q[NB-1:0];
		rw_we       = 1'b0;
		rw_waddr    = clr_addr;
		rw_wdata    = '0;
		rw_raddr    = rel_addr;
		d_we        = 1'b0;
		d_waddr     = out_addr;
		d_wdata     = {tvalid_q[ri_s1], dv};
		d_raddr     = pair_addr;
		t_we        = 1'b0;
		t_waddr     = ri_s1;
		t_wdata     = nd[TD_W-1:0];
		t_raddr     = col_q[NB-1:0];
		unique case (state_q)
			jap_pkg::ST_IDLE: begin
				if (start) begin
					unique case (jap_pkg::op_t'(op))
						jap_pkg::OP_ADD:     state_d = jap_pkg::ST_ADD_SCAN;
						jap_pkg::OP_COMPUTE: state_d = jap_pkg::ST_P_CLR;
						jap_pkg::OP_READ:    state_d = jap_pkg::ST_READ;
						jap_pkg::OP_CLEAR:   state_d = jap_pkg::ST_FIN;
						default:             state_d = jap_pkg::ST_IDLE;
					endcase
				end
			end
			jap_pkg::ST_ADD_SCAN: begin
				if (pair_match) begin
					// Parallel edge: keep the lighter weight in the existing slot.
					e_waddr = ei_s1;
					e_we    = w_q < rd_w;
					fin     = 1'b1;
					state_d = jap_pkg::ST_IDLE;
				end else if (!issue_e && !rv_s1) begin
					fin     = 1'b1;
					state_d = jap_pkg::ST_IDLE;
					if (add_new) begin
						e_we = 1'b1;
					end else begin
						fin_status = jap_pkg::STAT_FULL;
					end
				end
			end
			jap_pkg::ST_P_CLR: begin
				p_we    = 1'b1;
				p_waddr = col_q[NB-1:0];
				if (col_q == n_m1) begin
					state_d = jap_pkg::ST_E_RD;
				end
			end
			jap_pkg::ST_E_RD: begin
				if (issue_e) begin
					state_d = jap_pkg::ST_E_FROM;
				end else if (phase_q) begin
					state_d = jap_pkg::ST_DJ_INIT;
				end else if (pass_q == computed_n_q) begin
					state_d = jap_pkg::ST_RW_CLR;
				end
			end
			jap_pkg::ST_E_FROM: begin
				p_raddr = NB'(rd_from);
				state_d = edge_in ? jap_pkg::ST_E_TO : jap_pkg::ST_E_RD;
			end
			jap_pkg::ST_E_TO: begin
				p_raddr = NB'(et_q);
				state_d = jap_pkg::ST_E_UPD;
			end
			jap_pkg::ST_E_UPD: begin
				state_d = jap_pkg::ST_E_RD;
				if (phase_q) begin
					rw_we    = 1'b1;
					rw_waddr = edge_addr;
					rw_wdata = {1'b1, rwv[RW_W-1:0]};
				end else if (less) begin
					if (pass_q == computed_n_q) begin
						// An edge still relaxes after n passes: negative cycle.
						fin        = 1'b1;
						fin_status = jap_pkg::STAT_NEG;
						state_d    = jap_pkg::ST_IDLE;
					end else begin
						p_we    = 1'b1;
						p_wdata = cand[POT_W-1:0];
					end
				end
			end
			jap_pkg::ST_RW_CLR: begin
				rw_we = 1'b1;
				if ((col_q == NCW'(MAX_NODES - 1)) && (row_q == n_m1)) begin
					state_d = jap_pkg::ST_E_RD;
				end
			end
			jap_pkg::ST_DJ_INIT: begin
				p_raddr = src_q[NB-1:0];
				t_we    = 1'b1;
				t_waddr = src_q[NB-1:0];
				t_wdata = '0;
				state_d = jap_pkg::ST_DJ_POT;
			end
			jap_pkg::ST_DJ_POT: begin
				state_d = jap_pkg::ST_DJ_SEL;
			end
			jap_pkg::ST_DJ_SEL: begin
				if (scan_end) begin
					state_d = have_best_q ? jap_pkg::ST_DJ_REL : jap_pkg::ST_DJ_OUT;
				end
			end
			jap_pkg::ST_DJ_REL: begin
				t_we = relax_upd;
				if (scan_end) begin
					state_d = jap_pkg::ST_DJ_SEL;
				end
			end
			jap_pkg::ST_DJ_OUT: begin
				d_we = rv_s1;
				if (scan_end) begin
					if (src_q == n_m1) begin
						fin     = 1'b1;
						state_d = jap_pkg::ST_IDLE;
					end else begin
						state_d = jap_pkg::ST_DJ_INIT;
					end
				end
			end
			jap_pkg::ST_READ: begin
				rw_raddr = pair_addr;
				state_d  = jap_pkg::ST_READ2;
			end
			jap_pkg::ST_READ2: begin
				fin     = 1'b1;
				state_d = jap_pkg::ST_IDLE;
				if (!flag_done_q) begin
					fin_status = jap_pkg::STAT_NC;
				end else if (flag_cycle_q) begin
					fin_status = jap_pkg::STAT_NEG;
				end else if (in_range) begin
					fin_reach   = d_rdata[DV_W];
					fin_present = rw_pres;
					if (d_rdata[DV_W]) begin
						if (dv64 > 64'sh7FFF_FFFF) begin
							fin_dist = 32'sh7FFF_FFFF;
						end else if (dv64 < -64'sh8000_0000) begin
							fin_dist = -32'sh8000_0000;
						end else begin
							fin_dist = dv64[31:0];
						end
					end
					if (rw_pres) begin
						fin_rw = (rw64 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : rw64[30:0];
					end
				end
			end
			jap_pkg::ST_FIN: begin
				fin     = 1'b1;
				state_d = jap_pkg::ST_IDLE;
			end
			default: state_d = jap_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jap_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 6'd32;
			flag_done_q  <= 1'b0;
			flag_cycle_q <= 1'b0;
			edge_cnt_q   <= '0;
			idx_q        <= '0;
			computed_n_q <= '0;
			pass_q       <= '0;
			row_q        <= '0;
			col_q        <= '0;
			src_q        <= '0;
			phase_q      <= 1'b0;
			have_best_q  <= 1'b0;
			rv_s1        <= 1'b0;
			done_q       <= 1'b0;
			tvalid_q     <= '0;
			visited_q    <= '0;
		end else begin
			done_q <= fin;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
				flag_done_q  <= 1'b0;
			end
			unique case (state_q)
				jap_pkg::ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						rv_s1 <= 1'b0;
						col_q <= '0;
						if (jap_pkg::op_t'(op) == jap_pkg::OP_COMPUTE) begin
							computed_n_q <= n_c;
						end
						if (jap_pkg::op_t'(op) == jap_pkg::OP_CLEAR) begin
							edge_cnt_q  <= '0;
							flag_done_q <= 1'b0;
						end
					end
				end
				jap_pkg::ST_ADD_SCAN: begin
					rv_s1 <= issue_e && !pair_match;
					if (issue_e) begin
						idx_q <= idx_q + ECW'(1);
					end
					if (fin && (fin_status == jap_pkg::STAT_OK)) begin
						flag_done_q <= 1'b0;
					end
					if (fin && add_new) begin
						edge_cnt_q <= edge_cnt_q + ECW'(1);
					end
				end
				jap_pkg::ST_P_CLR: begin
					col_q   <= col_q + NCW'(1);
					idx_q   <= '0;
					pass_q  <= '0;
					phase_q <= 1'b0;
				end
				jap_pkg::ST_E_RD: begin
					if (!issue_e) begin
						idx_q <= '0;
						row_q <= '0;
						col_q <= '0;
						src_q <= '0;
						if (!phase_q && (pass_q != computed_n_q)) begin
							pass_q <= pass_q + NCW'(1);
						end
					end
				end
				jap_pkg::ST_E_FROM: begin
					if (!edge_in) begin
						idx_q <= idx_q + ECW'(1);
					end
				end
				jap_pkg::ST_E_UPD: begin
					idx_q <= idx_q + ECW'(1);
					if (fin) begin
						flag_done_q  <= 1'b1;
						flag_cycle_q <= 1'b1;
					end
				end
				jap_pkg::ST_RW_CLR: begin
					if (col_q == NCW'(MAX_NODES - 1)) begin
						col_q <= '0;
						row_q <= row_q + NCW'(1);
					end else begin
						col_q <= col_q + NCW'(1);
					end
					idx_q   <= '0;
					phase_q <= 1'b1;
				end
				jap_pkg::ST_DJ_INIT: begin
					tvalid_q              <= '0;
					tvalid_q[src_q[NB-1:0]] <= 1'b1;
					visited_q             <= '0;
				end
				jap_pkg::ST_DJ_POT: begin
					col_q       <= '0;
					rv_s1       <= 1'b0;
					have_best_q <= 1'b0;
				end
				jap_pkg::ST_DJ_SEL: begin
					rv_s1 <= issue_n;
					if (issue_n) begin
						col_q <= col_q + NCW'(1);
					end
					if (sel_better) begin
						have_best_q <= 1'b1;
					end
					if (scan_end) begin
						col_q <= '0;
						if (have_best_q) begin
							visited_q[best_q] <= 1'b1;
						end
					end
				end
				jap_pkg::ST_DJ_REL: begin
					rv_s1 <= issue_n;
					if (issue_n) begin
						col_q <= col_q + NCW'(1);
					end
					if (relax_upd) begin
						tvalid_q[ri_s1] <= 1'b1;
					end
					if (scan_end) begin
						col_q       <= '0;
						have_best_q <= 1'b0;
					end
				end
				jap_pkg::ST_DJ_OUT: begin
					rv_s1 <= issue_n;
					if (issue_n) begin
						col_q <= col_q + NCW'(1);
					end
					if (scan_end) begin
						if (fin) begin
							flag_done_q  <= 1'b1;
							flag_cycle_q <= 1'b0;
						end else begin
							src_q <= src_q + NCW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == jap_pkg::ST_IDLE) && start) begin
			s_q <= src_node;
			d_q <= dst_node;
			w_q <= w_in;
		end
		ei_s1 <= idx_q[EA-1:0];
		ri_s1 <= col_q[NB-1:0];
		if (state_q == jap_pkg::ST_E_FROM) begin
			ef_q <= rd_from;
			et_q <= rd_to;
			ew_q <= rd_w;
		end
		if (state_q == jap_pkg::ST_E_TO) begin
			pf_q <= p_rdata;
		end
		if (state_q == jap_pkg::ST_DJ_POT) begin
			ps_q <= p_rdata;
		end
		if ((state_q == jap_pkg::ST_DJ_SEL) && sel_better) begin
			best_q   <= ri_s1;
			best_d_q <= t_rdata;
		end
		if (fin) begin
			status_q  <= fin_status;
			reach_q   <= fin_reach;
			dist_q    <= fin_dist;
			present_q <= fin_present;
			rw_q      <= fin_rw;
		end
	end

	assign busy              = state_q != jap_pkg::ST_IDLE;
	assign done              = done_q;
	assign status            = status_q;
	assign reachable         = reach_q;
	assign distance          = dist_q;
	assign edge_present      = present_q;
	assign reweighted_weight = rw_q;

	`JAP_ASSERT(a_done_after_busy, clk, arst_n, done |-> $past(busy), "done without a transaction in progress")
	`JAP_ASSERT(a_start_takes_busy, clk, arst_n, (start && !busy) |=> busy, "accepted transaction did not raise busy")
	`JAP_ASSERT(a_fields_zero, clk, arst_n, (done && (status != jap_pkg::STAT_OK)) |-> (!reachable && !edge_present && (distance == 32'sd0) && (reweighted_weight == 31'd0)), "result fields set on a failed transaction")
	`JAP_ASSERT(a_full_only_when_full, clk, arst_n, (done && (status == jap_pkg::STAT_FULL)) |-> (edge_cnt_q == ECW'(MAX_EDGES)), "store full reported below capacity")
	`JAP_ASSERT_NEVER(a_edge_cnt_range, clk, arst_n, edge_cnt_q > ECW'(MAX_EDGES), "edge count beyond capacity")

endmodule

FILE: tb/sv/apsp_checker.sv
module apsp_checker
	import jap_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_wdata,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         op,
	input  logic [4:0]         src_node,
	input  logic [4:0]         dst_node,
	input  logic signed [15:0] edge_weight,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic               reachable,
	input  logic signed [31:0] distance,
	input  logic               edge_present,
	input  logic [30:0]        reweighted_weight,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 32;
	localparam int EDGES = 256;

	typedef struct {
		logic [1:0]         status;
		logic               reachable;
		logic signed [31:0] distance;
		logic               edge_present;
		logic [30:0]        rw_weight;
	} path_result_t;

	path_result_t expected_results[$];

	// Graph shadow state.
	int     node_reg;
	int     edge_total;
	int     edge_from[EDGES];
	int     edge_to[EDGES];
	longint edge_w[EDGES];
	longint pot[NODES];
	longint rw_mat[NODES*NODES];
	bit     rw_has[NODES*NODES];
	longint dist_mat[NODES*NODES];
	bit     dist_has[NODES*NODES];
	bit     is_computed;
	bit     has_cycle;
	int     solved_n;

	function automatic int active_nodes();
		if (node_reg < 1) return 1;
		if (node_reg > NODES) return NODES;
		return node_reg;
	endfunction

	function automatic bit edge_in_range(int i, int n);
		return edge_from[i] < n && edge_to[i] < n;
	endfunction

	function automatic void shortest_from(int s, int n);
		longint td[NODES];
		bit     tv[NODES];
		bit     vis[NODES];
		int     best;
		longint nd;
		for (int i = 0; i < NODES; i++) begin
			td[i] = 0;
			tv[i] = 0;
			vis[i] = 0;
		end
		tv[s] = 1;
		for (int r = 0; r < n; r++) begin
			best = n;
			for (int i = 0; i < n; i++)
				if (!vis[i] && tv[i] && (best == n || td[i] < td[best])) best = i;
			if (best == n) break;
			vis[best] = 1;
			for (int i = 0; i < n; i++) begin
				if (rw_has[best*NODES+i]) begin
					nd = td[best] + rw_mat[best*NODES+i];
					if (!tv[i] || nd < td[i]) begin
						td[i] = nd;
						tv[i] = 1;
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			dist_has[s*NODES+i] = tv[i];
			dist_mat[s*NODES+i] = tv[i] ? td[i] - pot[s] + pot[i] : 0;
		end
	endfunction

	function automatic logic [1:0] solve_graph();
		int n;
		n = active_nodes();
		solved_n = n;
		for (int i = 0; i < NODES; i++) pot[i] = 0;
		// Virtual source: every potential starts at zero.
		for (int k = 0; k < n; k++)
			for (int i = 0; i < edge_total; i++)
				if (edge_in_range(i, n) && pot[edge_from[i]] + edge_w[i] < pot[edge_to[i]])
					pot[edge_to[i]] = pot[edge_from[i]] + edge_w[i];
		for (int i = 0; i < edge_total; i++) begin
			if (edge_in_range(i, n) && pot[edge_from[i]] + edge_w[i] < pot[edge_to[i]]) begin
				is_computed = 1;
				has_cycle = 1;
				return STAT_NEG;
			end
		end
		for (int i = 0; i < NODES*NODES; i++) begin
			rw_has[i] = 0;
			rw_mat[i] = 0;
		end
		for (int i = 0; i < edge_total; i++) begin
			if (edge_in_range(i, n)) begin
				rw_has[edge_from[i]*NODES+edge_to[i]] = 1;
				rw_mat[edge_from[i]*NODES+edge_to[i]] =
					edge_w[i] + pot[edge_from[i]] - pot[edge_to[i]];
			end
		end
		for (int s = 0; s < n; s++) shortest_from(s, n);
		is_computed = 1;
		has_cycle = 0;
		return STAT_OK;
	endfunction

	function automatic path_result_t predict_transaction(op_t code, int s, int d, longint w);
		path_result_t r;
		bit found;
		int ix;
		longint v;
		r = '{STAT_OK, 1'b0, 32'sd0, 1'b0, 31'd0};
		case (code)
			OP_ADD: begin
				found = 0;
				for (int i = 0; i < edge_total; i++) begin
					if (edge_from[i] == s && edge_to[i] == d) begin
						if (w < edge_w[i]) edge_w[i] = w;
						found = 1;
						break;
					end
				end
				if (!found) begin
					if (edge_total >= EDGES) begin
						r.status = STAT_FULL;
					end else begin
						edge_from[edge_total] = s;
						edge_to[edge_total] = d;
						edge_w[edge_total] = w;
						edge_total++;
					end
				end
				if (r.status == STAT_OK) is_computed = 0;
			end
			OP_COMPUTE: r.status = solve_graph();
			OP_READ: begin
				if (!is_computed) begin
					r.status = STAT_NC;
				end else if (has_cycle) begin
					r.status = STAT_NEG;
				end else if (s < solved_n && d < solved_n) begin
					ix = s*NODES + d;
					if (dist_has[ix]) begin
						v = dist_mat[ix];
						if (v > 64'sd2147483647) v = 64'sd2147483647;
						if (v < -64'sd2147483648) v = -64'sd2147483648;
						r.reachable = 1;
						r.distance = v[31:0];
					end
					if (rw_has[ix]) begin
						v = rw_mat[ix];
						if (v < 0) v = 0;
						if (v > 64'sd2147483647) v = 64'sd2147483647;
						r.edge_present = 1;
						r.rw_weight = v[30:0];
					end
				end
			end
			default: begin
				edge_total = 0;
				is_computed = 0;
			end
		endcase
		return r;
	endfunction

	initial begin
		node_reg = NODES;
		edge_total = 0;
		is_computed = 0;
		has_cycle = 0;
		solved_n = 0;
		fail_count = 0;
		pending = 0;
		for (int i = 0; i < NODES; i++) pot[i] = 0;
	end

	always @(posedge clk) begin
		path_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (reachable !== want.reachable) begin
						$error("reachable: expected %0d, got %0d", want.reachable, reachable);
						fail_count++;
					end
					if (distance !== want.distance) begin
						$error("distance: expected %0d, got %0d", want.distance, distance);
						fail_count++;
					end
					if (edge_present !== want.edge_present) begin
						$error("edge_present: expected %0d, got %0d",
							want.edge_present, edge_present);
						fail_count++;
					end
					if (reweighted_weight !== want.rw_weight) begin
						$error("reweighted_weight: expected %0d, got %0d",
							want.rw_weight, reweighted_weight);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				node_reg = cfg_wdata;
				is_computed = 0;
			end
			if (start && !busy)
				expected_results.push_back(predict_transaction(op_t'(op), src_node, dst_node,
					longint'(edge_weight)));
			pending = expected_results.size();
		end
	end
endmodule

FILE: tb/sv/tb_johnson_all_pairs_shortest_paths_core.sv
module tb_johnson_all_pairs_shortest_paths_core;
	import jap_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [5:0]         cfg_wdata = '0;
	logic               start = 0;
	logic               busy;
	logic [1:0]         op = OP_READ;
	logic [4:0]         src_node = '0;
	logic [4:0]         dst_node = '0;
	logic signed [15:0] edge_weight = '0;
	logic               done;
	logic [1:0]         status;
	logic               reachable;
	logic signed [31:0] distance;
	logic               edge_present;
	logic [30:0]        reweighted_weight;
	int                 fail_count;
	int                 pending;
	int                 idle_pct = 0;
	int                 cycles = 0;
	int                 sent = 0;
	int                 n_nodes;
	int                 n_edges;

	always #5 clk = ~clk;

	johnson_all_pairs_shortest_paths_core dut (.*);

	apsp_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Called right after a rising edge; returns at the edge that accepts the transaction.
	task automatic send(op_t code, int s, int d, int w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		op <= code;
		src_node <= s;
		dst_node <= d;
		edge_weight <= w;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_nodes(int v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic int pick_node();
		// Mostly nodes in use, sometimes anything the field allows.
		if ($urandom_range(9) == 0) return $urandom_range(31);
		return $urandom_range(n_nodes - 1);
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part.
		send(OP_READ, 0, 0, 0);
		set_nodes(5);
		send(OP_ADD, 0, 1, 32767);
		send(OP_ADD, 1, 2, -32768);
		send(OP_ADD, 0, 1, 100);
		send(OP_ADD, 2, 3, 5);
		send(OP_ADD, 4, 9, -7);
		send(OP_ADD, 31, 31, 1);
		send(OP_COMPUTE, 0, 0, 0);
		send(OP_READ, 0, 2, 0);
		send(OP_READ, 2, 0, 0);
		send(OP_READ, 0, 1, 0);
		send(OP_READ, 9, 0, 0);
		send(OP_READ, 31, 31, 0);
		send(OP_ADD, 2, 0, 0);
		send(OP_READ, 0, 1, 0);
		send(OP_COMPUTE, 0, 0, 0);
		send(OP_READ, 0, 1, 0);
		send(OP_CLEAR, 0, 0, 0);
		send(OP_READ, 0, 1, 0);
		set_nodes(0);
		send(OP_ADD, 0, 0, 0);
		send(OP_COMPUTE, 0, 0, 0);
		send(OP_READ, 0, 0, 0);
		set_nodes(63);
		send(OP_ADD, 0, 31, -3);
		send(OP_ADD, 31, 5, 9);
		send(OP_COMPUTE, 0, 0, 0);
		send(OP_READ, 0, 5, 0);
		send(OP_READ, 31, 0, 0);

		// Fill the edge store, then one new pair and one parallel edge.
		set_nodes(4);
		send(OP_CLEAR, 0, 0, 0);
		for (int i = 0; i < 256; i++) send(OP_ADD, i % 32, i / 32, $urandom_range(50));
		send(OP_ADD, 31, 31, 3);
		send(OP_ADD, 1, 2, -1);
		send(OP_COMPUTE, 0, 0, 0);
		send(OP_READ, 0, 2, 0);
		send(OP_READ, 1, 2, 0);
		send(OP_CLEAR, 0, 0, 0);

		// Random graphs under several sender idle rates.
		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 84;
				2: idle_pct = 0;
				default: idle_pct = 38;
			endcase
			while (sent < (ph + 1) * 28) begin
				n_nodes = $urandom_range(2, 8);
				set_nodes($urandom_range(3) == 0 ? $urandom_range(63) % 9 : n_nodes);
				if (chk.node_reg >= 1) n_nodes = chk.node_reg;
				else n_nodes = 1;
				send(OP_CLEAR, pick_node(), pick_node(), $urandom);
				n_edges = $urandom_range(12);
				for (int e = 0; e < n_edges; e++) begin
					if ($urandom_range(7) == 0)
						send(OP_ADD, pick_node(), pick_node(), $urandom);
					else
						send(OP_ADD, pick_node(), pick_node(), $urandom_range(24) - 3);
				end
				if ($urandom_range(5) == 0) send(OP_READ, pick_node(), pick_node(), $urandom);
				send(OP_COMPUTE, pick_node(), pick_node(), $urandom);
				if ($urandom_range(3) == 0) drain();
				for (int r = $urandom_range(3, 8); r > 0; r--)
					send(OP_READ, pick_node(), pick_node(), $urandom);
			end
		end

		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
